// ----- hdl/sha256_byte_stream_hash_assert.svh -----
// assertion macros for the sha-256 byte stream hash
`ifndef SHA256_BYTE_STREAM_HASH_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASH_ASSERT_SVH

// implication checked every clock outside reset
`define SHA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication checked outside reset
`define SHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ----- hdl/sha_pkg.sv -----
// package: sha-256 constants and round functions
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;
    localparam logic [7:0]  PadByte    = 8'h80;
    localparam logic [6:0]  LenPos     = 7'd56;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_word;

    localparam t_word InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam t_word RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
    function automatic t_word bsig0(input t_word x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction
    function automatic t_word bsig1(input t_word x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction
    function automatic t_word ssig0(input t_word x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction
    function automatic t_word ssig1(input t_word x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction
endpackage
`default_nettype wire

// ----- hdl/sha_stream_if.sv -----
// valid/ready stream interfaces for input and digest words
`timescale 1ns / 1ps
`default_nettype none
interface sha_in_if;
    logic             valid;
    logic             ready;
    sha_pkg::t_in_word payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sha_out_if;
    logic              valid;
    logic              ready;
    sha_pkg::t_out_word payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hdl/sha256_byte_stream_hash.sv -----
// top level: sha-256 over a byte stream with one shared round unit
// sequence: a byte word that does not fill the block is taken while idle
// a byte that completes a block starts the round states, then the fold state
// a last word adds one or two padded blocks, then the eight digest words are shown
// input is not ready outside idle: while rounds, fold, padding or digest output run
// reset: synchronous active low, restores the initial hash and clears counts
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_byte_stream_hash_assert.svh"
module sha256_byte_stream_hash (
    input wire logic i_clk,
    input wire logic i_rst_n,
    sha_in_if.sink   i_in,
    sha_out_if.source o_out
);
    import sha_pkg::*;

    // sequencer states
    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StRound = 3'd1;
    localparam logic [2:0] StFold  = 3'd2;
    localparam logic [2:0] StPad   = 3'd3;
    localparam logic [2:0] StOut   = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_fill;       // bytes held in the block
    logic [63:0] r_len;        // message length in bits
    t_word       r_h [8];      // chained hash
    t_word       r_v [8];      // working variables
    t_word       r_w [16];     // schedule window, as a shift register
    logic [5:0]  r_rnd;        // round counter
    logic        r_fin;        // message ended, padding in progress
    logic [2:0]  r_oidx;       // digest word being shown

    // the block is a 16-word shift line: bytes shift in at the tail word
    t_word w_new;
    t_word t1, t2;

    assign i_in.ready  = (r_state == StIdle);
    assign o_out.valid = (r_state == StOut);
    assign o_out.payload.digest_word = r_h[r_oidx];
    assign o_out.payload.word_index  = r_oidx;
    assign o_out.payload.last_word   = (r_oidx == 3'd7);

    // shared round unit: schedule word and one compression round
    always_comb begin
        if (r_rnd < 6'd16) begin
            w_new = r_w[0];
        end else begin
            w_new = r_w[0] + ssig0(r_w[1]) + r_w[9] + ssig1(r_w[14]);
        end
        t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + RoundK[r_rnd] + w_new;
        t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // byte packing into the tail: the window shifts left one byte per byte
    logic        push;
    logic [7:0]  push_byte;
    logic        in_acc;
    assign in_acc = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= StIdle;
            r_fill   <= '0;
            r_len    <= '0;
            r_rnd    <= '0;
            r_fin    <= 1'b0;
            r_oidx   <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= InitH[i];
        end else begin
            r_state <= n_state;
            if (push) begin
                for (int i = 0; i < 15; i++) r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
                r_w[15] <= {r_w[15][23:0], push_byte};
            end
            unique case (r_state)
                StIdle: begin
                    if (in_acc) begin
                        if (i_in.payload.byte_present) begin
                            r_fill <= r_fill + 6'd1;
                            r_len  <= r_len + 64'd8;
                        end
                        r_fin <= i_in.payload.last;
                        if (n_state == StRound) begin
                            r_rnd <= '0;
                            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        end
                    end
                end
                StPad: begin
                    r_fill <= r_fill + 6'd1;
                    if (n_state == StRound) begin
                        r_rnd    <= '0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    end
                end
                StRound: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_new;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd  <= r_rnd + 6'd1;
                end
                StFold: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                end
                StOut: begin
                    if (o_out.ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_fill <= '0;
                            r_len  <= '0;
                            r_fin  <= 1'b0;
                            for (int i = 0; i < 8; i++) r_h[i] <= InitH[i];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // padding bookkeeping: marker placed, length bytes follow
    logic r_marked;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marked <= 1'b0;
        end else if (r_state == StOut) begin
            r_marked <= 1'b0;
        end else if (r_state == StPad) begin
            r_marked <= 1'b1;
        end
    end

    // length goes only into the block that will be the last one
    logic r_overflow;
    logic pad_len_blocked;
    assign pad_len_blocked = r_overflow;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overflow <= 1'b0;
        end else if (r_state == StPad && !r_marked) begin
            r_overflow <= (r_fill >= LenPos[5:0]);
        end else if (r_state == StFold) begin
            r_overflow <= 1'b0;
        end
    end

    // byte written into the tail during padding
    logic [7:0] pad_byte;
    logic [2:0] len_sel;
    always_comb begin
        len_sel  = r_fill[2:0];
        pad_byte = 8'h00;
        if (!r_marked) begin
            pad_byte = PadByte;
        end else if (r_fill >= LenPos[5:0] && !pad_len_blocked) begin
            pad_byte = r_len[63 - 8*len_sel -: 8];
        end
    end

    always_comb begin
        push      = 1'b0;
        push_byte = i_in.payload.data_byte;
        if (r_state == StIdle && in_acc && i_in.payload.byte_present) begin
            push = 1'b1;
        end else if (r_state == StPad) begin
            push      = 1'b1;
            push_byte = pad_byte;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            StIdle: begin
                if (in_acc) begin
                    if (i_in.payload.byte_present && r_fill == 6'd63) begin
                        n_state = StRound;
                    end else if (i_in.payload.last) begin
                        n_state = StPad;
                    end
                end
            end
            StPad:   if (r_fill == 6'd63) n_state = StRound;
            StRound: if (r_rnd == 6'd63) n_state = StFold;
            StFold: begin
                if (!r_fin) n_state = StIdle;
                else if (r_marked && !r_overflow) n_state = StOut;
                else n_state = StPad;
            end
            StOut:   if (o_out.ready && r_oidx == 3'd7) n_state = StIdle;
            default: n_state = StIdle;
        endcase
    end

    `SHA_ASSERT_IMP(a_out_only_final, o_out.valid, r_fin)
    `SHA_ASSERT_IMP(a_busy_not_ready, r_state != StIdle, !i_in.ready)
    `SHA_ASSERT_NEXT(a_round_to_fold, r_state == StRound && r_rnd == 6'd63, r_state == StFold)
    `SHA_ASSERT_NEXT(a_digest_restart,
        o_out.valid && o_out.ready && o_out.payload.last_word, r_fill == 6'd0 && r_len == 64'd0)
endmodule
`default_nettype wire

// ----- verif/sha256_byte_stream_hash_tb.sv -----
// testbench: sha-256 byte stream hash checked against a built-in digest predictor
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hash_tb;
    import sha_pkg::*;

    logic i_clk;
    logic i_rst_n;
    sha_in_if  in_if ();
    sha_out_if out_if ();

    sha256_byte_stream_hash dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    // predictor state
    logic [7:0]  msg_buf [64];
    int unsigned msg_fill;
    logic [63:0] msg_bits;
    t_word       hash_h [8];
    t_out_word   digest_q [$];
    int          errors;
    bit          quiet;
    int unsigned sent;

    // message lengths around the padding boundaries
    int          pad_lens [4] = '{55, 56, 63, 64};

    typedef struct {
        t_in_word    w;
        bit          fixed;
        logic [31:0] h0;
    } t_row;

    function automatic t_word rr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic digest_reset();
        msg_fill = 0;
        msg_bits = '0;
        for (int i = 0; i < 8; i++) hash_h[i] = InitH[i];
    endtask

    task automatic digest_compress();
        t_word w [16];
        t_word v [8];
        t_word s0, s1, t1, t2, wx;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
        for (int i = 0; i < 8; i++) v[i] = hash_h[i];
        for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
                wx = w[i];
            end else begin
                s0 = rr(w[(i-15)&15], 7) ^ rr(w[(i-15)&15], 18) ^ (w[(i-15)&15] >> 3);
                s1 = rr(w[(i-2)&15], 17) ^ rr(w[(i-2)&15], 19) ^ (w[(i-2)&15] >> 10);
                wx = w[i&15] + s0 + w[(i-7)&15] + s1;
                w[i&15] = wx;
            end
            t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + wx;
            t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_h[i] += v[i];
    endtask

    // absorb one accepted word; on last, pad and queue eight digest words
    task automatic digest_absorb(input t_in_word w);
        t_out_word o;
        if (w.byte_present) begin
            msg_buf[msg_fill] = w.data_byte;
            msg_fill++;
            msg_bits += 64'd8;
            if (msg_fill == 64) begin
                digest_compress();
                msg_fill = 0;
            end
        end
        if (w.last) begin
            msg_buf[msg_fill] = PadByte;
            msg_fill++;
            if (msg_fill > 56) begin
                while (msg_fill < 64) msg_buf[msg_fill++] = 8'h00;
                digest_compress();
                msg_fill = 0;
            end
            while (msg_fill < 56) msg_buf[msg_fill++] = 8'h00;
            for (int i = 0; i < 8; i++) msg_buf[56+i] = msg_bits[63-8*i -: 8];
            digest_compress();
            for (int i = 0; i < 8; i++) begin
                o.digest_word = hash_h[i];
                o.word_index  = 3'(i);
                o.last_word   = (i == 7);
                digest_q = {digest_q, o};
            end
            digest_reset();
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // send one word, idling at random unless quiet; valid stays up for the next word
    task automatic send_word(input t_in_word w);
        while (!quiet && $urandom_range(99) < 6) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= w;
        do @(posedge i_clk); while (!in_if.ready);
        digest_absorb(w);
        sent++;
        @(negedge i_clk);
    endtask

    // drop valid before the sender pauses
    task automatic idle_in();
        in_if.valid <= 1'b0;
    endtask

    function automatic t_in_word mk(input logic [7:0] b, input logic p, input logic l);
        t_in_word w;
        w.data_byte = b; w.byte_present = p; w.last = l;
        return w;
    endfunction

    // receiver: random stall, compare on every accepted digest word
    t_out_word exp_w;
    t_out_word got_w;
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got_w = out_if.payload;
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest word act=%h", $time, got_w);
                errors++;
            end else begin
                exp_w = digest_q.pop_front();
                if (got_w.digest_word !== exp_w.digest_word) begin
                    $display("%0t: digest_word exp=%h act=%h", $time,
                             exp_w.digest_word, got_w.digest_word);
                    errors++;
                end
                if (got_w.word_index !== exp_w.word_index) begin
                    $display("%0t: word_index exp=%0d act=%0d", $time,
                             exp_w.word_index, got_w.word_index);
                    errors++;
                end
                if (got_w.last_word !== exp_w.last_word) begin
                    $display("%0t: last_word exp=%0d act=%0d", $time,
                             exp_w.last_word, got_w.last_word);
                    errors++;
                end
            end
        end
    end
    always @(negedge i_clk) out_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 6);

    // directed rows; first digest word typed in where it is well known
    t_row rows [$];
    initial begin
        t_row r;
        int n, kind;
        errors = 0; sent = 0; quiet = 1'b0;
        in_if.valid = 1'b0;
        in_if.payload = '0;
        out_if.ready = 1'b1;
        i_rst_n = 1'b0;
        digest_reset();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty message: e3b0c442...
        r.w = mk(8'h00, 1'b0, 1'b1); r.fixed = 1; r.h0 = 32'he3b0c442; rows = {rows, r};
        // idle word, then "abc": ba7816bf...
        r.fixed = 0;
        r.w = mk(8'hff, 1'b0, 1'b0); rows = {rows, r};
        r.w = mk(8'h61, 1'b1, 1'b0); rows = {rows, r};
        r.w = mk(8'h62, 1'b1, 1'b0); rows = {rows, r};
        r.w = mk(8'h63, 1'b1, 1'b1); r.fixed = 1; r.h0 = 32'hba7816bf; rows = {rows, r};
        r.fixed = 0;
        // byte extremes, last carrying a byte
        r.w = mk(8'h00, 1'b1, 1'b0); rows = {rows, r};
        r.w = mk(8'hff, 1'b1, 1'b0); rows = {rows, r};
        r.w = mk(8'h55, 1'b1, 1'b0); rows = {rows, r};
        r.w = mk(8'haa, 1'b1, 1'b1); rows = {rows, r};
        // single byte with separate empty last
        r.w = mk(8'h80, 1'b1, 1'b0); rows = {rows, r};
        r.w = mk(8'h01, 1'b0, 1'b1); rows = {rows, r};
        foreach (rows[i]) begin
            send_word(rows[i].w);
            if (rows[i].fixed && hash_h[0] == InitH[0]) begin
                // predictor just finished a digest: check its first word
                if (digest_q[digest_q.size()-8].digest_word !== rows[i].h0) begin
                    $display("%0t: known digest exp=%h act=%h", $time, rows[i].h0,
                             digest_q[digest_q.size()-8].digest_word);
                    errors++;
                end
            end
        end

        // padding boundaries: 55, 56, 63 and 64 bytes
        foreach (pad_lens[k]) begin
            n = pad_lens[k];
            for (int j = 0; j < n; j++)
                send_word(mk(8'($urandom), 1'b1, j == n - 1));
        end

        // pause until every digest word has come back
        idle_in();
        while (digest_q.size() != 0) @(negedge i_clk);

        // random messages, mostly well formed, some idle words
        while (sent < 320) begin
            kind = $urandom_range(9);
            n = (kind < 6) ? $urandom_range(12) : (kind < 9) ? $urandom_range(40) : 0;
            if (sent > 300) quiet = 1'b0;
            else if (sent > 260) quiet = 1'b1;
            for (int j = 0; j < n; j++) begin
                if ($urandom_range(9) == 0) send_word(mk(8'($urandom), 1'b0, 1'b0));
                send_word(mk(8'($urandom), 1'b1, 1'b0));
            end
            send_word(mk(8'($urandom), 1'($urandom_range(1)), 1'b1));
        end
        quiet = 1'b0;
        idle_in();

        while (digest_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (errors == 0)
            $display("sha256_byte_stream_hash: match");
        else
            $display("sha256_byte_stream_hash: mismatch");
        $finish;
    end

    initial begin
        #20ms;
        $display("sha256_byte_stream_hash: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
